// ----- rtl/s2da_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// s2da_pkg
// Shared types, constants and the shift-add-3 steps for the decimal text core.
// ----------------------------------------------------------------------------
package s2da_pkg;

    localparam int unsigned BinWidth     = 32;
    localparam int unsigned NumDigits    = 10;
    localparam int unsigned BcdWidth     = 4 * NumDigits;
    localparam int unsigned StepsPerStage = 8;
    localparam int unsigned NumDabStages = BinWidth / StepsPerStage;

    localparam logic [7:0] CharZero  = 8'h30;
    localparam logic [7:0] CharMinus = 8'h2D;

    typedef logic [3:0] t_digit_idx;

    // One item in flight through the conversion pipeline.
    typedef struct packed {
        logic                neg;
        logic [BcdWidth-1:0] bcd;
        logic [BinWidth-1:0] bin;
    } t_stage;

    // Eight double-dabble steps: adjust every BCD digit, then shift left by one.
    function automatic t_stage f_dabble(input t_stage s);
        t_stage                        r;
        logic [BcdWidth+BinWidth-1:0]  w;
        r = s;
        for (int k = 0; k < StepsPerStage; k++) begin
            for (int d = 0; d < NumDigits; d++) begin
                if (r.bcd[4*d +: 4] >= 4'd5) begin
                    r.bcd[4*d +: 4] = r.bcd[4*d +: 4] + 4'd3;
                end
            end
            w     = {r.bcd, r.bin} << 1;
            r.bcd = w[BcdWidth+BinWidth-1:BinWidth];
            r.bin = w[BinWidth-1:0];
        end
        return r;
    endfunction

endpackage

// ----- rtl/s2da_mag.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// s2da_mag
// Entry stage: takes the sign and registers the unsigned magnitude.
// ----------------------------------------------------------------------------
module s2da_mag (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  logic [31:0]                 i_value,
    output logic                        o_ready,
    input  logic                        i_ready,
    output logic                        o_valid,
    output s2da_pkg::t_stage            o_data
);

    logic             r_valid;
    s2da_pkg::t_stage r_data;
    s2da_pkg::t_stage n_data;

    assign o_ready = !r_valid || i_ready;

    always_comb begin
        n_data.neg = i_value[31];
        n_data.bcd = '0;
        n_data.bin = i_value[31] ? (32'd0 - i_value) : i_value;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// ----- rtl/s2da_dabble.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// s2da_dabble
// One pipeline stage of the binary to BCD conversion: eight shift-add-3 steps.
// ----------------------------------------------------------------------------
module s2da_dabble (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  s2da_pkg::t_stage i_data,
    output logic             o_ready,
    input  logic             i_ready,
    output logic             o_valid,
    output s2da_pkg::t_stage o_data
);

    logic             r_valid;
    s2da_pkg::t_stage r_data;

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= s2da_pkg::f_dabble(i_data);
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// ----- rtl/s2da_emit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// s2da_emit
// Output sequencer: sends the sign, then the significant digits, one a cycle.
// ----------------------------------------------------------------------------
module s2da_emit (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  s2da_pkg::t_stage i_data,
    output logic             o_ready,
    output logic             o_strobe,
    output logic [7:0]       o_character,
    output logic             o_last
);

    logic                              r_active;
    logic                              r_sign;
    s2da_pkg::t_digit_idx              r_idx;
    logic [s2da_pkg::BcdWidth-1:0]     r_bcd;
    logic                              r_strobe;
    logic [7:0]                        r_character;
    logic                              r_last;

    logic                              n_active;
    logic                              n_sign;
    s2da_pkg::t_digit_idx              n_idx;
    logic                              n_strobe;
    logic [7:0]                        n_character;
    logic                              n_last;
    s2da_pkg::t_digit_idx              w_top;
    logic                              w_final;
    logic                              w_load;

    // Index of the most significant nonzero digit; zero keeps digit 0.
    always_comb begin
        w_top = '0;
        for (int d = 0; d < s2da_pkg::NumDigits; d++) begin
            if (i_data.bcd[4*d +: 4] != 4'd0) begin
                w_top = s2da_pkg::t_digit_idx'(d);
            end
        end
    end

    assign w_final = r_active && !r_sign && (r_idx == '0);
    assign o_ready = !r_active || w_final;
    assign w_load  = o_ready && i_valid;

    always_comb begin
        n_active    = r_active;
        n_sign      = r_sign;
        n_idx       = r_idx;
        n_strobe    = 1'b0;
        n_character = r_character;
        n_last      = 1'b0;
        if (r_active) begin
            n_strobe = 1'b1;
            if (r_sign) begin
                n_character = s2da_pkg::CharMinus;
                n_sign      = 1'b0;
            end else begin
                n_character = s2da_pkg::CharZero + {4'd0, r_bcd[4*r_idx +: 4]};
                n_last      = (r_idx == '0);
                n_idx       = r_idx - 4'd1;
                if (r_idx == '0) begin
                    n_active = 1'b0;
                end
            end
        end
        // Load the next item on the cycle the current one sends its last digit.
        if (w_load) begin
            n_active = 1'b1;
            n_sign   = i_data.neg;
            n_idx    = w_top;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_sign   <= 1'b0;
            r_idx    <= '0;
            r_strobe <= 1'b0;
            r_last   <= 1'b0;
        end else begin
            r_active <= n_active;
            r_sign   <= n_sign;
            r_idx    <= n_idx;
            r_strobe <= n_strobe;
            r_last   <= n_last;
        end
    end

    always_ff @(posedge i_clk) begin
        r_character <= n_character;
        if (w_load) begin
            r_bcd <= i_data.bcd;
        end
    end

    assign o_strobe    = r_strobe;
    assign o_character = r_character;
    assign o_last      = r_last;

endmodule

// ----- rtl/signed_int_to_decimal_ascii_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_core
// Signed 32-bit integer to decimal ASCII text, one character per strobe.
//
// Input: drive i_value and raise start; the item is taken at a rising edge
// where start is high and busy is low. Output: each character shows on
// o_character for one cycle with o_strobe high, most significant first, a
// minus sign ahead of negative values, no leading zeros; o_last marks the
// final character. One to eleven characters per item.
// Path: the first character passes the magnitude stage, four double-dabble
// stages of eight steps, the sequencer load and the output register. The
// sequencer sends one character a cycle and loads the next item while the
// previous last character is formed, so the characters of successive items
// follow with no gap when the next item waits; the pipeline stages in front
// hold further items meanwhile and busy rises when they fill.
// The receiver cannot stall: results are never held back.
// Reset (synchronous, active low) drops all items in flight.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] i_value,
    output logic        o_strobe,
    output logic [7:0]  o_character,
    output logic        o_last
);

    localparam int unsigned NSt = s2da_pkg::NumDabStages;

    s2da_pkg::t_stage w_data  [NSt+1];
    logic             w_valid [NSt+1];
    logic             w_ready [NSt+1];
    logic             w_in_ready;

    s2da_mag u_mag (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (start),
        .i_value (i_value),
        .o_ready (w_in_ready),
        .i_ready (w_ready[0]),
        .o_valid (w_valid[0]),
        .o_data  (w_data[0])
    );

    for (genvar g = 0; g < NSt; g++) begin : g_dab
        s2da_dabble u_dab (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_valid[g]),
            .i_data  (w_data[g]),
            .o_ready (w_ready[g]),
            .i_ready (w_ready[g+1]),
            .o_valid (w_valid[g+1]),
            .o_data  (w_data[g+1])
        );
    end

    s2da_emit u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (w_valid[NSt]),
        .i_data      (w_data[NSt]),
        .o_ready     (w_ready[NSt]),
        .o_strobe    (o_strobe),
        .o_character (o_character),
        .o_last      (o_last)
    );

    assign busy = !w_in_ready;

endmodule
